// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the preset table engine RTL
// Clocked, reset-gated property checks that report through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/spte_pkg.sv =====
// ----------------------------------------------------------------------------
// spte_pkg
// Types and codes shared by the preset table engine controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spte_pkg;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_DELETE,
    OP_CLEAR,
    OP_SEL_FREQ,
    OP_SEL_INDEX,
    OP_UP,
    OP_DOWN,
    OP_TICK
  } op_t;

  typedef enum logic [3:0] {
    ST_IGNORED,
    ST_SELECTED,
    ST_UPDATED,
    ST_ADDED,
    ST_PREVIEWED,
    ST_DELETED,
    ST_CLEARED,
    ST_STEPS_REJ,
    ST_INDEX_REJ
  } status_t;

  typedef struct packed {
    op_t                op;
    logic [31:0]        freq_khz;
    logic signed [31:0] step_count;
    logic [5:0]         entry_index;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic        move;
    logic [30:0] target_steps;
    logic [31:0] tuned_khz;
    logic [31:0] shown_khz;
    logic [5:0]  selected_index;
    logic [5:0]  preview_index;
    logic [6:0]  entry_count;
  } result_t;

  // Configuration register indices (byte address 4*i)
  localparam logic REG_ENDSTOP = 1'b0;
  localparam logic REG_DELAY   = 1'b1;

  localparam logic [30:0] ENDSTOP_RESET = 31'd10000;
  localparam logic [15:0] DELAY_RESET   = 16'd2000;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC,
    PTR_COUNT,
    PTR_CUR,
    PTR_IDX,
    PTR_PREV
  } ptr_op_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_PTR,
    RD_PTR_UP,
    RD_PTR_DOWN,
    RD_PREV
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_COPY,
    WR_ITEM,
    WR_STEPS
  } wr_sel_t;

  typedef enum logic [3:0] {
    REG_NONE,
    REG_CLEAR,
    REG_DELETE,
    REG_UP,
    REG_DOWN,
    REG_FIRST,
    REG_TICK,
    REG_TAKE_RD,
    REG_TAKE_ITEM
  } reg_op_t;

  typedef struct packed {
    logic    latch;
    ptr_op_t ptr_op;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    reg_op_t reg_op;
    logic    count_inc;
    logic    pos_init;
    logic    pos_mark;
    logic    status_we;
    status_t status;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic count_zero;
    logic count_one;
    logic full;
    logic ptr_end;
    logic ptr_last;
    logic ptr_at_pos;
    logic cur_in_table;
    logic idx_ok;
    logic prev_ok;
    logic prev_at_end;
    logic prev_zero;
    logic add_reject;
    logic key_match;
    logic key_before;
    logic rd_steps_ok;
    logic item_steps_neg;
    logic tick_fire;
    logic pos_found;
  } flags_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD_RD,
    S_ADD_EV,
    S_ADD_END,
    S_SHIFT_CHK,
    S_SHIFT_WR,
    S_INSERT,
    S_DEL_CHK,
    S_DEL_WR,
    S_DEL_FIX,
    S_SF_RD,
    S_SF_EV,
    S_IX_RD,
    S_IX_EV,
    S_TICK_EV,
    S_SHOW,
    S_EMIT
  } state_t;

endpackage

// ===== hw/rtl/spte_dp.sv =====
// ----------------------------------------------------------------------------
// spte_dp
// Preset memory, scan pointer, selection and preview registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spte_dp #(
  parameter int TABLE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  spte_pkg::cmd_t   cmd,
  input  spte_pkg::item_t  item_in,
  input  logic [30:0]      endstop,
  input  logic [15:0]      delay,
  output spte_pkg::flags_t flags,
  output spte_pkg::result_t result
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Entry word: frequency in the upper half, raw steps in the lower half
  logic [63:0] mem [TABLE_DEPTH];
  logic [63:0] rd_data;

  spte_pkg::item_t    item;
  spte_pkg::status_t  status;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   ptr;
  logic [CNT_W-1:0]   pos;
  logic               pos_found;
  logic [IDX_W-1:0]   cur;
  logic [IDX_W-1:0]   prev;
  logic [31:0]        tuned;
  logic [30:0]        target;
  logic [15:0]        age;

  logic [CNT_W-1:0]   rd_addr;
  logic [CNT_W-1:0]   count_dec;
  logic [31:0]        rd_freq;
  logic [31:0]        rd_steps;
  logic [63:0]        wr_data;

  assign rd_freq   = rd_data[63:32];
  assign rd_steps  = rd_data[31:0];
  assign count_dec = count - CNT_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      spte_pkg::RD_PTR_UP:   rd_addr = ptr + CNT_W'(1);
      spte_pkg::RD_PTR_DOWN: rd_addr = ptr - CNT_W'(1);
      spte_pkg::RD_PREV:     rd_addr = CNT_W'(prev);
      default:               rd_addr = ptr;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      spte_pkg::WR_ITEM:  wr_data = {item.freq_khz, item.step_count};
      spte_pkg::WR_STEPS: wr_data = {rd_freq, item.step_count};
      default:            wr_data = rd_data;
    endcase
  end

  // Single write port at the scan pointer, single registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_sel != spte_pkg::WR_NONE) begin
      mem[ptr[IDX_W-1:0]] <= wr_data;
    end
    if (cmd.rd_sel != spte_pkg::RD_NONE) begin
      rd_data <= mem[rd_addr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item <= item_in;
    end
    if (cmd.status_we) begin
      status <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      pos       <= '0;
      pos_found <= 1'b0;
    end else begin
      case (cmd.ptr_op)
        spte_pkg::PTR_ZERO:  ptr <= '0;
        spte_pkg::PTR_INC:   ptr <= ptr + CNT_W'(1);
        spte_pkg::PTR_DEC:   ptr <= ptr - CNT_W'(1);
        spte_pkg::PTR_COUNT: ptr <= count;
        spte_pkg::PTR_CUR:   ptr <= CNT_W'(cur);
        spte_pkg::PTR_IDX:   ptr <= CNT_W'(item.entry_index);
        spte_pkg::PTR_PREV:  ptr <= CNT_W'(prev);
        default:             ptr <= ptr;
      endcase
      if (cmd.pos_init) begin
        pos       <= count;
        pos_found <= 1'b0;
      end else if (cmd.pos_mark) begin
        pos       <= ptr;
        pos_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      cur    <= '0;
      prev   <= '0;
      tuned  <= '0;
      target <= '0;
      age    <= '0;
    end else begin
      if (cmd.count_inc) begin
        count <= count + CNT_W'(1);
      end
      case (cmd.reg_op)
        spte_pkg::REG_CLEAR: begin
          count <= '0;
          cur   <= '0;
        end
        spte_pkg::REG_DELETE: begin
          // shrink, then step the preview back unless it is at entry 0 or no entry remains, and make it current
          count <= count_dec;
          if (count_dec == CNT_W'(1)) begin
            prev <= '0;
            cur  <= '0;
            age  <= '0;
          end else if (count_dec != '0 && prev != '0) begin
            prev <= prev - IDX_W'(1);
            cur  <= prev - IDX_W'(1);
            age  <= '0;
          end else begin
            cur <= prev;
          end
        end
        spte_pkg::REG_UP: begin
          prev <= prev + IDX_W'(1);
          age  <= '0;
        end
        spte_pkg::REG_DOWN: begin
          prev <= prev - IDX_W'(1);
          age  <= '0;
        end
        spte_pkg::REG_FIRST: begin
          prev <= '0;
          age  <= '0;
        end
        spte_pkg::REG_TICK: begin
          if (age != 16'hFFFF) begin
            age <= age + 16'd1;
          end
        end
        spte_pkg::REG_TAKE_RD: begin
          cur    <= ptr[IDX_W-1:0];
          prev   <= ptr[IDX_W-1:0];
          target <= rd_steps[30:0];
          tuned  <= rd_freq;
        end
        spte_pkg::REG_TAKE_ITEM: begin
          cur    <= ptr[IDX_W-1:0];
          prev   <= ptr[IDX_W-1:0];
          target <= item.step_count[30:0];
          tuned  <= item.freq_khz;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    flags.op             = item.op;
    flags.count_zero     = (count == '0);
    flags.count_one      = (count == CNT_W'(1));
    flags.full           = (count >= CNT_W'(TABLE_DEPTH));
    flags.ptr_end        = (ptr == count);
    flags.ptr_last       = ((ptr + CNT_W'(1)) == count);
    flags.ptr_at_pos     = (ptr == pos);
    flags.cur_in_table   = (CNT_W'(cur) < count);
    flags.idx_ok         = (32'(item.entry_index) < 32'(count));
    flags.prev_ok        = (CNT_W'(prev) < count);
    flags.prev_at_end    = ((CNT_W'(prev) + CNT_W'(1)) >= count);
    flags.prev_zero      = (prev == '0);
    flags.add_reject     = (item.step_count >= $signed({1'b0, endstop}));
    flags.key_match      = (rd_freq == item.freq_khz);
    flags.key_before     = (item.freq_khz != '0) &&
                           ((rd_freq == '0) || (item.freq_khz < rd_freq));
    flags.rd_steps_ok    = !rd_steps[31] && (rd_steps[30:0] <= endstop);
    flags.item_steps_neg = item.step_count[31];
    flags.tick_fire      = (cur != prev) && (age > delay);
    flags.pos_found      = pos_found;
  end

  always_comb begin
    result.status         = status;
    result.move           = (status == spte_pkg::ST_SELECTED);
    result.target_steps   = target;
    result.tuned_khz      = tuned;
    result.shown_khz      = flags.prev_ok ? rd_freq : 32'd0;
    result.selected_index = 6'(cur);
    result.preview_index  = 6'(prev);
    result.entry_count    = 7'(count);
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(TABLE_DEPTH), "entry count past depth")
  `ASSERT_ALWAYS(a_count_step, clk, rst, $past(rst) || count == $past(count) || count == '0 || count == $past(count) + CNT_W'(1) || count == $past(count) - CNT_W'(1), "entry count jumped")

endmodule

// ===== hw/rtl/spte_ctrl.sv =====
// ----------------------------------------------------------------------------
// spte_ctrl
// Sequencer for the preset table operations; drives the datapath commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spte_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             out_free,
  input  spte_pkg::flags_t flags,
  output spte_pkg::cmd_t   cmd,
  output logic             idle,
  output logic             emit
);

  spte_pkg::state_t state;
  spte_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spte_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    idle       = 1'b0;
    emit       = 1'b0;
    case (state)
      spte_pkg::S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = spte_pkg::S_DISPATCH;
        end
      end
      spte_pkg::S_DISPATCH: begin
        cmd.status_we = 1'b1;
        cmd.status    = spte_pkg::ST_IGNORED;
        state_next    = spte_pkg::S_SHOW;
        case (flags.op)
          spte_pkg::OP_ADD: begin
            if (flags.add_reject) begin
              cmd.status = spte_pkg::ST_STEPS_REJ;
            end else begin
              cmd.ptr_op   = spte_pkg::PTR_ZERO;
              cmd.pos_init = 1'b1;
              state_next   = spte_pkg::S_ADD_RD;
            end
          end
          spte_pkg::OP_DELETE: begin
            if (!flags.count_zero) begin
              cmd.ptr_op = spte_pkg::PTR_CUR;
              state_next = flags.cur_in_table ? spte_pkg::S_DEL_CHK : spte_pkg::S_DEL_FIX;
            end
          end
          spte_pkg::OP_CLEAR: begin
            cmd.reg_op = spte_pkg::REG_CLEAR;
            cmd.status = spte_pkg::ST_CLEARED;
          end
          spte_pkg::OP_SEL_FREQ: begin
            if (!flags.count_zero) begin
              cmd.ptr_op = spte_pkg::PTR_ZERO;
              state_next = spte_pkg::S_SF_RD;
            end
          end
          spte_pkg::OP_SEL_INDEX: begin
            if (!flags.count_zero) begin
              if (!flags.idx_ok) begin
                cmd.status = spte_pkg::ST_INDEX_REJ;
              end else begin
                cmd.ptr_op = spte_pkg::PTR_IDX;
                state_next = spte_pkg::S_IX_RD;
              end
            end
          end
          spte_pkg::OP_UP: begin
            if (flags.count_one) begin
              cmd.reg_op = spte_pkg::REG_FIRST;
              cmd.status = spte_pkg::ST_PREVIEWED;
            end else if (!flags.count_zero && !flags.prev_at_end) begin
              cmd.reg_op = spte_pkg::REG_UP;
              cmd.status = spte_pkg::ST_PREVIEWED;
            end
          end
          spte_pkg::OP_DOWN: begin
            if (flags.count_one) begin
              cmd.reg_op = spte_pkg::REG_FIRST;
              cmd.status = spte_pkg::ST_PREVIEWED;
            end else if (!flags.count_zero && !flags.prev_zero) begin
              cmd.reg_op = spte_pkg::REG_DOWN;
              cmd.status = spte_pkg::ST_PREVIEWED;
            end
          end
          default: begin
            cmd.reg_op = spte_pkg::REG_TICK;
            state_next = spte_pkg::S_TICK_EV;
          end
        endcase
      end
      // add: look for a duplicate key and the insertion point in one pass
      spte_pkg::S_ADD_RD: begin
        if (flags.ptr_end) begin
          state_next = spte_pkg::S_ADD_END;
        end else begin
          cmd.rd_sel = spte_pkg::RD_PTR;
          state_next = spte_pkg::S_ADD_EV;
        end
      end
      spte_pkg::S_ADD_EV: begin
        if (flags.key_match) begin
          cmd.wr_sel    = spte_pkg::WR_STEPS;
          cmd.status_we = 1'b1;
          cmd.status    = spte_pkg::ST_UPDATED;
          state_next    = spte_pkg::S_SHOW;
        end else begin
          cmd.pos_mark = flags.key_before && !flags.pos_found;
          cmd.ptr_op   = spte_pkg::PTR_INC;
          state_next   = spte_pkg::S_ADD_RD;
        end
      end
      spte_pkg::S_ADD_END: begin
        if (flags.full) begin
          state_next = spte_pkg::S_SHOW;
        end else begin
          cmd.ptr_op = spte_pkg::PTR_COUNT;
          state_next = spte_pkg::S_SHIFT_CHK;
        end
      end
      spte_pkg::S_SHIFT_CHK: begin
        if (flags.ptr_at_pos) begin
          state_next = spte_pkg::S_INSERT;
        end else begin
          cmd.rd_sel = spte_pkg::RD_PTR_DOWN;
          state_next = spte_pkg::S_SHIFT_WR;
        end
      end
      spte_pkg::S_SHIFT_WR: begin
        cmd.wr_sel = spte_pkg::WR_COPY;
        cmd.ptr_op = spte_pkg::PTR_DEC;
        state_next = spte_pkg::S_SHIFT_CHK;
      end
      spte_pkg::S_INSERT: begin
        cmd.wr_sel    = spte_pkg::WR_ITEM;
        cmd.count_inc = 1'b1;
        cmd.status_we = 1'b1;
        if (flags.item_steps_neg) begin
          cmd.status = spte_pkg::ST_ADDED;
        end else begin
          cmd.reg_op = spte_pkg::REG_TAKE_ITEM;
          cmd.status = spte_pkg::ST_SELECTED;
        end
        state_next = spte_pkg::S_SHOW;
      end
      // delete: close the gap from the current entry upwards
      spte_pkg::S_DEL_CHK: begin
        if (flags.ptr_last) begin
          state_next = spte_pkg::S_DEL_FIX;
        end else begin
          cmd.rd_sel = spte_pkg::RD_PTR_UP;
          state_next = spte_pkg::S_DEL_WR;
        end
      end
      spte_pkg::S_DEL_WR: begin
        cmd.wr_sel = spte_pkg::WR_COPY;
        cmd.ptr_op = spte_pkg::PTR_INC;
        state_next = spte_pkg::S_DEL_CHK;
      end
      spte_pkg::S_DEL_FIX: begin
        cmd.reg_op    = spte_pkg::REG_DELETE;
        cmd.status_we = 1'b1;
        cmd.status    = spte_pkg::ST_DELETED;
        state_next    = spte_pkg::S_SHOW;
      end
      spte_pkg::S_SF_RD: begin
        if (flags.ptr_end) begin
          state_next = spte_pkg::S_SHOW;
        end else begin
          cmd.rd_sel = spte_pkg::RD_PTR;
          state_next = spte_pkg::S_SF_EV;
        end
      end
      spte_pkg::S_SF_EV: begin
        if (flags.key_match) begin
          cmd.status_we = 1'b1;
          if (flags.rd_steps_ok) begin
            cmd.reg_op = spte_pkg::REG_TAKE_RD;
            cmd.status = spte_pkg::ST_SELECTED;
          end else begin
            cmd.status = spte_pkg::ST_STEPS_REJ;
          end
          state_next = spte_pkg::S_SHOW;
        end else begin
          cmd.ptr_op = spte_pkg::PTR_INC;
          state_next = spte_pkg::S_SF_RD;
        end
      end
      spte_pkg::S_IX_RD: begin
        cmd.rd_sel = spte_pkg::RD_PTR;
        state_next = spte_pkg::S_IX_EV;
      end
      spte_pkg::S_IX_EV: begin
        cmd.status_we = 1'b1;
        if (flags.rd_steps_ok) begin
          cmd.reg_op = spte_pkg::REG_TAKE_RD;
          cmd.status = spte_pkg::ST_SELECTED;
        end else begin
          cmd.status = spte_pkg::ST_STEPS_REJ;
        end
        state_next = spte_pkg::S_SHOW;
      end
      spte_pkg::S_TICK_EV: begin
        state_next = spte_pkg::S_SHOW;
        if (flags.tick_fire && !flags.count_zero) begin
          if (!flags.prev_ok) begin
            cmd.status_we = 1'b1;
            cmd.status    = spte_pkg::ST_INDEX_REJ;
          end else begin
            cmd.ptr_op = spte_pkg::PTR_PREV;
            state_next = spte_pkg::S_IX_RD;
          end
        end
      end
      spte_pkg::S_SHOW: begin
        cmd.rd_sel = spte_pkg::RD_PREV;
        state_next = spte_pkg::S_EMIT;
      end
      spte_pkg::S_EMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = spte_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = spte_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sorted_preset_table_engine_top.sv =====
// Acceptance to out_valid runs DISPATCH, the operation's states, SHOW (preview read) and EMIT.
//   Select by index and a committing tick read one entry; select by freq reads to a match or the end;
//   delete moves later entries down; add scans for a duplicate and the insert point, then shifts up.
// One transaction at a time, with one registered read per entry visited; EMIT waits for a free
//   output register, and the next input is taken in the cycle after the result is registered.
// Reset (rst, synchronous, active high) empties the table, clears selection, preview and age,
//   and loads endstop 10000 and preview delay 2000; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
// sorted_preset_table_engine_top
// Sorted preset table: frequency keyed presets with selection and preview.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_preset_table_engine_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  // input transactions
  input  logic               in_valid,
  output logic               in_stall,
  input  spte_pkg::item_t    in_data,
  // result transactions
  output logic               out_valid,
  input  logic               out_stall,
  output spte_pkg::result_t  out_data,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Configuration registers: endstop at byte 0, preview delay at byte 4.
  logic [30:0] endstop;
  logic [15:0] delay;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      endstop <= spte_pkg::ENDSTOP_RESET;
      delay   <= spte_pkg::DELAY_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == spte_pkg::REG_ENDSTOP) begin
        endstop <= pwdata[30:0];
      end else begin
        delay <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == spte_pkg::REG_DELAY) ? {16'd0, delay} : {1'b0, endstop};

  // Controller / datapath pair
  spte_pkg::cmd_t    cmd;
  spte_pkg::flags_t  flags;
  spte_pkg::result_t result;
  logic              idle;
  logic              emit;
  logic              out_free;

  // The output register frees as soon as the downstream takes its transaction; while a
  // result is held there, the controller can still take a new input but waits in EMIT to deliver it.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !idle;

  spte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (in_valid),
    .out_free (out_free),
    .flags    (flags),
    .cmd      (cmd),
    .idle     (idle),
    .emit     (emit)
  );

  spte_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .item_in (in_data),
    .endstop (endstop),
    .delay   (delay),
    .flags   (flags),
    .result  (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= result;
    end
  end

  `ASSERT_IMPLIES(a_emit_free, clk, rst, emit, !(out_valid && out_stall), "result overwrote a held transaction")
  `ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && !in_stall, in_stall, "second transaction taken while busy")

endmodule

// ===== bench/sorted_preset_table_engine_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_preset_table_engine_top_tb
// Self-checking bench for the sorted preset table engine. A behavioural copy
// of the table, selection and preview logic predicts every result; random
// add/select/preview/delete/clear/tick traffic is driven with random gaps and
// stalls, and the two configuration registers are moved between phases.
// ----------------------------------------------------------------------------

module sorted_preset_table_engine_top_tb;

  localparam int DEPTH     = 64;
  localparam int WDOG_MAX  = 20000;

  // Preset table predictor and queue of pending results
  class preset_scoreboard;
    logic [31:0] tbl_freq [DEPTH];
    logic [31:0] tbl_steps[DEPTH];
    int unsigned n_entries;
    int unsigned cur_idx, prev_idx;
    logic [31:0] tuned;
    logic [30:0] target;
    int unsigned age;
    logic [30:0] endstop;
    logic [15:0] delay;
    spte_pkg::result_t pending[$];
    int          n_errors;

    function void clear_state();
      for (int i = 0; i < DEPTH; i++) begin
        tbl_freq[i]  = '0;
        tbl_steps[i] = '0;
      end
      n_entries = 0; cur_idx = 0; prev_idx = 0;
      tuned = '0; target = '0; age = 0;
      endstop = spte_pkg::ENDSTOP_RESET; delay = spte_pkg::DELAY_RESET;
      n_errors = 0;
    endfunction

    function bit steps_in_range(logic [31:0] raw);
      longint s;
      s = longint'($signed(raw));
      return s >= 0 && s <= longint'(endstop);
    endfunction

    function void take(int unsigned idx, logic [31:0] f);
      cur_idx  = idx;
      prev_idx = idx;
      target   = tbl_steps[idx][30:0];
      tuned    = f;
    endfunction

    function spte_pkg::status_t pick_freq(logic [31:0] f);
      if (n_entries == 0) return spte_pkg::ST_IGNORED;
      for (int unsigned i = 0; i < n_entries; i++)
        if (tbl_freq[i] == f) begin
          if (!steps_in_range(tbl_steps[i])) return spte_pkg::ST_STEPS_REJ;
          take(i, f);
          return spte_pkg::ST_SELECTED;
        end
      return spte_pkg::ST_IGNORED;
    endfunction

    function spte_pkg::status_t pick_index(int unsigned idx);
      if (n_entries == 0) return spte_pkg::ST_IGNORED;
      if (idx >= n_entries) return spte_pkg::ST_INDEX_REJ;
      if (!steps_in_range(tbl_steps[idx])) return spte_pkg::ST_STEPS_REJ;
      take(idx, tbl_freq[idx]);
      return spte_pkg::ST_SELECTED;
    endfunction

    // zero sorts last
    function bit sorts_ahead(logic [31:0] a, logic [31:0] b);
      if (a == 0) return 0;
      if (b == 0) return 1;
      return a < b;
    endfunction

    function spte_pkg::status_t move_preview(int unsigned idx);
      prev_idx = idx;
      age = 0;
      return spte_pkg::ST_PREVIEWED;
    endfunction

    function spte_pkg::status_t step_down();
      if (n_entries == 1) return move_preview(0);
      if (n_entries == 0 || prev_idx == 0) return spte_pkg::ST_IGNORED;
      return move_preview(prev_idx - 1);
    endfunction

    function spte_pkg::status_t step_up();
      if (n_entries == 1) return move_preview(0);
      if (n_entries == 0 || prev_idx >= n_entries - 1) return spte_pkg::ST_IGNORED;
      return move_preview(prev_idx + 1);
    endfunction

    function spte_pkg::status_t add_preset(logic [31:0] f, logic [31:0] s);
      int unsigned pos;
      if (longint'($signed(s)) >= longint'(endstop)) return spte_pkg::ST_STEPS_REJ;
      for (int unsigned i = 0; i < n_entries; i++)
        if (tbl_freq[i] == f) begin
          tbl_steps[i] = s;
          return spte_pkg::ST_UPDATED;
        end
      if (n_entries >= DEPTH) return spte_pkg::ST_IGNORED;
      pos = n_entries;
      for (int unsigned i = 0; i < n_entries; i++)
        if (sorts_ahead(f, tbl_freq[i])) begin
          pos = i;
          break;
        end
      for (int unsigned i = n_entries; i > pos; i--) begin
        tbl_freq[i]  = tbl_freq[i-1];
        tbl_steps[i] = tbl_steps[i-1];
      end
      tbl_freq[pos]  = f;
      tbl_steps[pos] = s;
      n_entries++;
      return (pick_freq(f) == spte_pkg::ST_SELECTED) ? spte_pkg::ST_SELECTED
                                                      : spte_pkg::ST_ADDED;
    endfunction

    function spte_pkg::status_t delete_current();
      spte_pkg::status_t dummy;
      if (n_entries == 0) return spte_pkg::ST_IGNORED;
      if (cur_idx < n_entries) begin
        for (int unsigned i = cur_idx; i + 1 < n_entries; i++) begin
          tbl_freq[i]  = tbl_freq[i+1];
          tbl_steps[i] = tbl_steps[i+1];
        end
        tbl_freq[n_entries-1]  = '0;
        tbl_steps[n_entries-1] = '0;
      end
      n_entries--;
      if (cur_idx >= n_entries && cur_idx > 0)
        cur_idx = (n_entries > 0) ? n_entries - 1 : 0;
      dummy = step_down();
      cur_idx = prev_idx;
      return spte_pkg::ST_DELETED;
    endfunction

    function void note_item(spte_pkg::item_t it);
      spte_pkg::status_t st;
      spte_pkg::result_t r;
      st = spte_pkg::ST_IGNORED;
      case (it.op)
        spte_pkg::OP_ADD:       st = add_preset(it.freq_khz, it.step_count);
        spte_pkg::OP_DELETE:    st = delete_current();
        spte_pkg::OP_CLEAR: begin
          for (int i = 0; i < DEPTH; i++) begin
            tbl_freq[i] = '0;
            tbl_steps[i] = '0;
          end
          n_entries = 0;
          cur_idx = 0;
          st = spte_pkg::ST_CLEARED;
        end
        spte_pkg::OP_SEL_FREQ:  st = pick_freq(it.freq_khz);
        spte_pkg::OP_SEL_INDEX: st = pick_index(it.entry_index);
        spte_pkg::OP_UP:        st = step_up();
        spte_pkg::OP_DOWN:      st = step_down();
        default: begin
          if (age < 65535) age++;
          if (cur_idx != prev_idx && age > delay) st = pick_index(prev_idx);
        end
      endcase
      r.status         = st;
      r.move           = (st == spte_pkg::ST_SELECTED);
      r.target_steps   = target;
      r.tuned_khz      = tuned;
      r.shown_khz      = tbl_freq[prev_idx];
      r.selected_index = cur_idx[5:0];
      r.preview_index  = prev_idx[5:0];
      r.entry_count    = n_entries[6:0];
      pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] exp_v);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, exp_v, $time);
      n_errors++;
    endtask

    task check_result(spte_pkg::result_t got);
      spte_pkg::result_t e;
      if (pending.size() == 0) begin
        report("unexpected result transaction", 32'd1, 32'd0);
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status)     report("status", 32'(got.status), 32'(e.status));
      if (got.move !== e.move)         report("move", 32'(got.move), 32'(e.move));
      if (got.target_steps !== e.target_steps)
        report("target_steps", 32'(got.target_steps), 32'(e.target_steps));
      if (got.tuned_khz !== e.tuned_khz) report("tuned_khz", got.tuned_khz, e.tuned_khz);
      if (got.shown_khz !== e.shown_khz) report("shown_khz", got.shown_khz, e.shown_khz);
      if (got.selected_index !== e.selected_index)
        report("selected_index", 32'(got.selected_index), 32'(e.selected_index));
      if (got.preview_index !== e.preview_index)
        report("preview_index", 32'(got.preview_index), 32'(e.preview_index));
      if (got.entry_count !== e.entry_count)
        report("entry_count", 32'(got.entry_count), 32'(e.entry_count));
    endtask
  endclass

  logic        clk, rst;
  logic        in_valid, in_stall;
  spte_pkg::item_t   in_data;
  logic        out_valid, out_stall;
  spte_pkg::result_t out_data;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  preset_scoreboard sb;
  int  idle_cycles;
  bit  hold_results;     // long receiver hold-off request
  logic [31:0] freq_pool[16];

  sorted_preset_table_engine_top u_dut (
    .clk, .rst,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Register write: setup then access phase, changed at falling edges
  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == spte_pkg::REG_ENDSTOP) sb.endstop = val[30:0];
    else sb.delay = val[15:0];
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Offer one transaction after a random gap; returns once accepted
  task automatic send_item(spte_pkg::item_t it, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    // let the block settle before touching registers
    repeat (300) @(posedge clk);
  endtask

  function automatic spte_pkg::item_t make_item(spte_pkg::op_t op, logic [31:0] f = 0,
                                                logic [31:0] s = 0, logic [5:0] ix = 0);
    spte_pkg::item_t it;
    it.op = op; it.freq_khz = f; it.step_count = s; it.entry_index = ix;
    return it;
  endfunction

  // Mostly meaningful traffic: a small pool of frequencies so duplicates and
  // select-by-frequency hits are common, steps mostly within the endstop.
  function automatic spte_pkg::item_t random_item();
    spte_pkg::item_t it;
    int r;
    r = $urandom_range(0, 99);
    it.op = (r < 30) ? spte_pkg::OP_ADD : (r < 38) ? spte_pkg::OP_DELETE :
            (r < 40) ? spte_pkg::OP_CLEAR : (r < 50) ? spte_pkg::OP_SEL_FREQ :
            (r < 60) ? spte_pkg::OP_SEL_INDEX : (r < 70) ? spte_pkg::OP_UP :
            (r < 80) ? spte_pkg::OP_DOWN : spte_pkg::OP_TICK;
    it.freq_khz    = ($urandom_range(0, 9) == 0) ? $urandom() :
                     freq_pool[$urandom_range(0, 15)];
    r = $urandom_range(0, 9);
    it.step_count  = (r == 0) ? $urandom() : (r == 1) ? -$signed($urandom_range(1, 100)) :
                     $urandom_range(0, sb.endstop > 20 ? sb.endstop + 5 : 30);
    it.entry_index = ($urandom_range(0, 3) == 0) ? 6'($urandom()) :
                     6'($urandom_range(0, 8));
    return it;
  endfunction

  // Receiver: random stall stretches, plus a long hold-off on request
  initial begin
    int hold;
    out_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_results) begin
        out_stall <= 1'b1;
        repeat (3000) @(negedge clk);
        hold_results = 0;
      end
      hold = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) hold = 0;
      out_stall <= (hold != 0);
      repeat (hold) @(negedge clk);
      out_stall <= 1'b0;
      @(negedge clk);
    end
  end

  // Result sampling and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("watchdog expired at %0t", $time);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    spte_pkg::item_t it;
    sb = new();
    sb.clear_state();
    idle_cycles = 0; hold_results = 0;
    rst = 1'b1;
    in_valid = 1'b0; in_data = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    for (int i = 0; i < 16; i++) freq_pool[i] = $urandom_range(1, 30000);
    freq_pool[0] = 32'hFFFF_FFFF;
    freq_pool[1] = 32'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table cases, adds at extremes, rejects, duplicates
    write_reg(spte_pkg::REG_DELAY, 32'd3);
    send_item(make_item(spte_pkg::OP_DELETE));
    send_item(make_item(spte_pkg::OP_UP));
    send_item(make_item(spte_pkg::OP_DOWN));
    send_item(make_item(spte_pkg::OP_SEL_INDEX, 0, 0, 6'd0));
    send_item(make_item(spte_pkg::OP_SEL_FREQ, 32'd7000));
    send_item(make_item(spte_pkg::OP_ADD, 32'd7000, 32'd10000));      // at endstop: reject
    send_item(make_item(spte_pkg::OP_ADD, 32'd7000, 32'h8000_0000));  // most negative
    send_item(make_item(spte_pkg::OP_ADD, 32'hFFFF_FFFF, 32'd9999));
    send_item(make_item(spte_pkg::OP_ADD, 32'd0, 32'd0));             // zero freq sorts last
    send_item(make_item(spte_pkg::OP_ADD, 32'd7000, 32'd500));
    send_item(make_item(spte_pkg::OP_ADD, 32'd7000, 32'd600));        // duplicate update
    send_item(make_item(spte_pkg::OP_ADD, 32'd3500, -32'sd5));        // added unselected
    send_item(make_item(spte_pkg::OP_SEL_FREQ, 32'd3500));            // bad steps
    send_item(make_item(spte_pkg::OP_SEL_FREQ, 32'd1234));            // no match
    send_item(make_item(spte_pkg::OP_SEL_INDEX, 0, 0, 6'd63));        // index reject
    send_item(make_item(spte_pkg::OP_SEL_INDEX, 0, 0, 6'd1));
    send_item(make_item(spte_pkg::OP_UP));
    send_item(make_item(spte_pkg::OP_UP));
    send_item(make_item(spte_pkg::OP_UP));
    for (int i = 0; i < 5; i++) send_item(make_item(spte_pkg::OP_TICK));  // commit preview
    send_item(make_item(spte_pkg::OP_DOWN));
    send_item(make_item(spte_pkg::OP_DELETE));
    send_item(make_item(spte_pkg::OP_CLEAR));
    send_item(make_item(spte_pkg::OP_UP));
    drain();

    // Random phases across register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(spte_pkg::REG_ENDSTOP, 32'd10000); write_reg(spte_pkg::REG_DELAY, 32'd0);
        end
        1: begin
          write_reg(spte_pkg::REG_ENDSTOP, 32'h7FFF_FFFF);
          write_reg(spte_pkg::REG_DELAY, 32'd2);
        end
        2: begin
          write_reg(spte_pkg::REG_ENDSTOP, 32'd0); write_reg(spte_pkg::REG_DELAY, 32'd1);
        end
        3: begin
          write_reg(spte_pkg::REG_ENDSTOP, 32'd500); write_reg(spte_pkg::REG_DELAY, 32'hFFFF);
        end
        4: begin
          write_reg(spte_pkg::REG_ENDSTOP, $urandom()); write_reg(spte_pkg::REG_DELAY, 32'd5);
        end
        default: begin
          write_reg(spte_pkg::REG_ENDSTOP, 32'd20000); write_reg(spte_pkg::REG_DELAY, 32'd4);
        end
      endcase
      if (ph == 5) begin
        // fill the table to its depth with distinct frequencies
        for (int i = 0; i < DEPTH + 2; i++)
          send_item(make_item(spte_pkg::OP_ADD, 32'd100 + 32'd7 * i,
                              $urandom_range(0, 100)), 1);
      end
      if (ph == 1) hold_results = 1;   // long receiver hold-off while traffic continues
      for (int n = 0; n < 270; n++) begin
        it = random_item();
        if (it.op == spte_pkg::OP_CLEAR && ph == 5) it.op = spte_pkg::OP_TICK;
        send_item(it, ph == 1 && n < 20);
        if (n == 135) drain();         // sender pauses until everything is back
      end
      drain();
    end

    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/spte_pkg.sv
hw/rtl/spte_dp.sv
hw/rtl/spte_ctrl.sv
hw/rtl/sorted_preset_table_engine_top.sv
bench/sorted_preset_table_engine_top_tb.sv
